/* sv/vdq_pkg.sv */
package vdq_pkg;

  // coordinate and derived widths
  localparam int CoordBits = 16;
  localparam int DiffBits  = CoordBits + 1;  // exact difference, never wraps
  localparam int MagBits   = CoordBits;      // |diff| <= 2^CoordBits - 1
  localparam int ProdBits  = MagBits + 3;    // room for 8x and 7x a magnitude
  localparam int StepBits  = 3;              // step 0..4
  localparam int DirBits   = 5;

  localparam int NumRows  = 8;
  localparam int NumSteps = 5;

  // code for two equal points
  localparam logic [DirBits-1:0] DirEqual = 5'h04;

  // octant selection, travels with the magnitudes
  typedef struct packed {
    logic dx_neg;   // dx < 0
    logic dy_neg;   // dy < 0
    logic x_major;  // |dx| >= |dy|
  } octant_t;

  // direction code per octant row and step, rows indexed {dx_neg, dy_neg, x_major}
  localparam logic [DirBits-1:0] DirTable [NumRows][NumSteps] = '{
    '{5'h00, 5'h01, 5'h02, 5'h03, 5'h04},
    '{5'h08, 5'h07, 5'h06, 5'h05, 5'h04},
    '{5'h10, 5'h0F, 5'h0E, 5'h0D, 5'h0C},
    '{5'h08, 5'h09, 5'h0A, 5'h0B, 5'h0C},
    '{5'h00, 5'h1F, 5'h1E, 5'h1D, 5'h1C},
    '{5'h18, 5'h19, 5'h1A, 5'h1B, 5'h1C},
    '{5'h10, 5'h11, 5'h12, 5'h13, 5'h14},
    '{5'h18, 5'h17, 5'h16, 5'h15, 5'h14}
  };

endpackage

/* sv/vdq_sector.sv */
module vdq_sector import vdq_pkg::*; (
  input  octant_t              octant_i,
  input  logic [MagBits-1:0]   small_i,
  input  logic [MagBits-1:0]   large_i,
  output logic [DirBits-1:0]   direction_o
);

  logic [ProdBits-1:0] small8;
  logic [ProdBits-1:0] large1, large3, large5, large7;
  logic [StepBits-1:0] step;

  // eight times the smaller magnitude and constant multiples of the larger
  always_comb begin
    small8 = {small_i, 3'b000};
    large1 = ProdBits'(large_i);
    large3 = ProdBits'(large_i) + {2'b00, large_i, 1'b0};
    large5 = ProdBits'(large_i) + {1'b0, large_i, 2'b00};
    large7 = {large_i, 3'b000} - ProdBits'(large_i);
  end

  // thresholds are nested, so the step is a count of the ones met
  always_comb begin
    step = StepBits'(small8 >= large1) + StepBits'(small8 >= large3)
         + StepBits'(small8 >= large5) + StepBits'(small8 >= large7);
  end

  assign direction_o = DirTable[octant_i][step];

endmodule

/* sv/vector_direction_quantizer_32.sv */
// 32-sector direction quantizer. Raise start_i with two points and the
// direction code from the first point toward the second (0 north, 8 east,
// 16 south, 24 west; y grows downward on screen) appears registered on
// direction_o, marked by a one-cycle done_o. A new word is taken in
// every cycle: busy_o stays low, and since the receiver cannot stall, each
// result must be captured in the cycle done_o is high. The pipeline has
// four register stages: difference, magnitude, octant select, step compare
// and table lookup. Equal points give code 4.
module vector_direction_quantizer_32 import vdq_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [CoordBits-1:0] from_x_i,
  input  logic signed [CoordBits-1:0] from_y_i,
  input  logic signed [CoordBits-1:0] to_x_i,
  input  logic signed [CoordBits-1:0] to_y_i,
  output logic                        done_o,
  output logic [DirBits-1:0]          direction_o
);

  logic accept;

  logic                       v1_q, v2_q, v3_q, v4_q;
  logic signed [DiffBits-1:0] dx_q, dy_q, dx_d, dy_d;
  logic [MagBits-1:0]         adx_q, ady_q, adx_d, ady_d;
  logic                       dxn_q, dyn_q;
  octant_t                    oct_q, oct_d;
  logic [MagBits-1:0]         small_q, large_q, small_d, large_d;
  logic [DirBits-1:0]         dir_q, dir_d;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // stage 1: exact differences, screen y flipped
  always_comb begin
    dx_d = DiffBits'(to_x_i) - DiffBits'(from_x_i);
    dy_d = DiffBits'(from_y_i) - DiffBits'(to_y_i);
  end

  // stage 2: magnitudes and signs
  always_comb begin
    adx_d = dx_q[DiffBits-1] ? MagBits'(-dx_q) : MagBits'(dx_q);
    ady_d = dy_q[DiffBits-1] ? MagBits'(-dy_q) : MagBits'(dy_q);
  end

  // stage 3: major axis, ties go to x
  always_comb begin
    oct_d.dx_neg  = dxn_q;
    oct_d.dy_neg  = dyn_q;
    oct_d.x_major = (adx_q >= ady_q);
    small_d = oct_d.x_major ? ady_q : adx_q;
    large_d = oct_d.x_major ? adx_q : ady_q;
  end

  // stage 4: step compares and code lookup
  vdq_sector u_sector (
    .octant_i    (oct_q),
    .small_i     (small_q),
    .large_i     (large_q),
    .direction_o (dir_d)
  );

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    adx_q   <= adx_d;
    ady_q   <= ady_d;
    dxn_q   <= dx_q[DiffBits-1];
    dyn_q   <= dy_q[DiffBits-1];
    oct_q   <= oct_d;
    small_q <= small_d;
    large_q <= large_d;
    dir_q   <= dir_d;
  end

  assign done_o      = v4_q;
  assign direction_o = dir_q;

`ifndef NO_ASSERTIONS
  // every accepted word leaves the pipeline with done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("result missing four cycles after accept");

  // no result without a matching accepted word
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result without a matching accept");

  // equal points map to the tie code
  a_equal_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && from_x_i == to_x_i && from_y_i == to_y_i)
      |-> ##4 (direction_o == DirEqual))
    else $error("equal points did not give the tie code");

  // straight east stays east
  a_east: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && from_y_i == to_y_i && to_x_i > from_x_i)
      |-> ##4 (direction_o == 5'h08))
    else $error("pure east vector misquantized");
`endif

endmodule

/* bench/vector_direction_quantizer_32_tb.sv */
`timescale 1ns / 100ps

module vector_direction_quantizer_32_tb import vdq_pkg::*;;

  localparam int HalfPeriod    = 5;
  localparam int ResetCycles   = 8;
  localparam int MaxGap        = 19;
  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 12;
  localparam int MaxReports    = 10;
  localparam int CoordMin      = -(1 << (CoordBits - 1));
  localparam int CoordMax      = (1 << (CoordBits - 1)) - 1;
  localparam int CoordSpan     = (1 << CoordBits) - 1;

  // sector code per octant row {dx_neg, dy_neg, x_major} and step
  localparam logic [DirBits-1:0] SectorCode [8][5] = '{
    '{5'h00, 5'h01, 5'h02, 5'h03, 5'h04},
    '{5'h08, 5'h07, 5'h06, 5'h05, 5'h04},
    '{5'h10, 5'h0F, 5'h0E, 5'h0D, 5'h0C},
    '{5'h08, 5'h09, 5'h0A, 5'h0B, 5'h0C},
    '{5'h00, 5'h1F, 5'h1E, 5'h1D, 5'h1C},
    '{5'h18, 5'h19, 5'h1A, 5'h1B, 5'h1C},
    '{5'h10, 5'h11, 5'h12, 5'h13, 5'h14},
    '{5'h18, 5'h17, 5'h16, 5'h15, 5'h14}
  };

  logic                        clk_i    = 1'b0;
  logic                        rst_ni   = 1'b0;
  logic                        start_i  = 1'b0;
  logic signed [CoordBits-1:0] from_x_i = '0;
  logic signed [CoordBits-1:0] from_y_i = '0;
  logic signed [CoordBits-1:0] to_x_i   = '0;
  logic signed [CoordBits-1:0] to_y_i   = '0;
  logic                        busy_o;
  logic                        done_o;
  logic [DirBits-1:0]          direction_o;

  logic [DirBits-1:0] expected_dirs[$];
  int                 error_count  = 0;
  int                 stall_cycles = 0;
  bit                 idle_on      = 1'b1;

  vector_direction_quantizer_32 i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .from_x_i    (from_x_i),
    .from_y_i    (from_y_i),
    .to_x_i      (to_x_i),
    .to_y_i      (to_y_i),
    .done_o      (done_o),
    .direction_o (direction_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // direction code from (fx, fy) toward (tx, ty), screen y flipped
  function automatic logic [DirBits-1:0] predict_direction(
    input logic signed [CoordBits-1:0] fx,
    input logic signed [CoordBits-1:0] fy,
    input logic signed [CoordBits-1:0] tx,
    input logic signed [CoordBits-1:0] ty
  );
    longint  dx, dy, adx, ady, minor, major;
    octant_t oct;
    int      step;
    dx = tx;
    dx = dx - fx;
    dy = fy;
    dy = dy - ty;
    oct.dx_neg  = (dx < 0);
    oct.dy_neg  = (dy < 0);
    adx = oct.dx_neg ? -dx : dx;
    ady = oct.dy_neg ? -dy : dy;
    oct.x_major = (adx >= ady);
    major = oct.x_major ? adx : ady;
    minor = oct.x_major ? ady : adx;
    // step counts odd multiples of the major axis reached by 8x minor
    step = 0;
    for (int k = 1; k <= 7; k += 2) begin
      if (minor * 8 >= major * k) step++;
    end
    return SectorCode[int'(oct)][step];
  endfunction

  task automatic note_error(input string msg);
    if (error_count < MaxReports) $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  // present one word, hold it until taken, then queue its expected code
  task automatic send_points(
    input logic signed [CoordBits-1:0] fx,
    input logic signed [CoordBits-1:0] fy,
    input logic signed [CoordBits-1:0] tx,
    input logic signed [CoordBits-1:0] ty
  );
    int gap;
    bit stalled;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    from_x_i <= fx;
    from_y_i <= fy;
    to_x_i   <= tx;
    to_y_i   <= ty;
    forever begin
      @(negedge clk_i);
      stalled = busy_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
    expected_dirs.push_back(predict_direction(fx, fy, tx, ty));
  endtask

  // place a pair with the given dx and dy at a random spot in range
  task automatic send_offset(input int dx, input int dy);
    int ax, ay, base_x, base_y;
    int fx, fy, tx, ty;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    base_x = int'($urandom_range(0, CoordSpan - ax)) + CoordMin;
    base_y = int'($urandom_range(0, CoordSpan - ay)) + CoordMin;
    fx = (dx >= 0) ? base_x : base_x + ax;
    tx = (dx >= 0) ? base_x + ax : base_x;
    ty = (dy >= 0) ? base_y : base_y + ay;
    fy = (dy >= 0) ? base_y + ay : base_y;
    send_points(fx, fy, tx, ty);
  endtask

  function automatic logic signed [CoordBits-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return CoordMin;
      1:       return CoordMax;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      5:       return CoordMin + 1;
      6:       return CoordMax - 1;
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    start_i <= 1'b0;
    while (expected_dirs.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_reset();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
  endtask

  // equal points, compass axes, full span, diagonals and exact thresholds
  task automatic test_directed();
    send_points(0, 0, 0, 0);
    send_points(CoordMin, CoordMin, CoordMin, CoordMin);
    send_points(CoordMax, CoordMax, CoordMax, CoordMax);
    send_offset(0, 5);
    send_offset(5, 0);
    send_offset(0, -5);
    send_offset(-5, 0);
    send_offset(CoordSpan, 0);
    send_offset(-CoordSpan, 0);
    send_offset(0, CoordSpan);
    send_offset(0, -CoordSpan);
    send_offset(7, 7);
    send_offset(7, -7);
    send_offset(-7, 7);
    send_offset(-7, -7);
    send_offset(CoordSpan, CoordSpan);
    send_offset(-CoordSpan, -CoordSpan);
    send_offset(1, 8);
    send_offset(-3, 8);
    send_offset(5, -8);
    send_offset(-7, -8);
    send_offset(8, 7);
    send_offset(8, -6);
  endtask

  // uniform words: every coordinate bit toggles
  task automatic test_random_points();
    for (int i = 0; i < 400; i++) begin
      if (i % 40 == 0) idle_on = $urandom_range(0, 1);
      send_points($urandom(), $urandom(), $urandom(), $urandom());
    end
  endtask

  // minor axis on, just under and just over each step threshold
  task automatic test_boundary_points();
    int major, minor, k, adx, ady;
    for (int i = 0; i < 700; i++) begin
      if (i % 40 == 0) idle_on = $urandom_range(0, 1);
      major = ($urandom_range(0, 9) == 0) ? $urandom_range(1, CoordSpan)
                                          : $urandom_range(1, 64);
      k = 2 * $urandom_range(0, 3) + 1;
      minor = (k * major) / 8 + int'($urandom_range(0, 3)) - 1;
      if (minor < 0) minor = 0;
      if (minor > major) minor = major;
      if ($urandom_range(0, 1)) begin
        adx = major;
        ady = minor;
      end else begin
        adx = minor;
        ady = major;
      end
      send_offset($urandom_range(0, 1) ? -adx : adx,
                  $urandom_range(0, 1) ? -ady : ady);
    end
  endtask

  // coordinates drawn mostly from the ends and the middle of the range
  task automatic test_extreme_points();
    for (int i = 0; i < 350; i++) begin
      if (i % 40 == 0) idle_on = $urandom_range(0, 1);
      send_points(pick_coord(), pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  // compare each result word with the oldest expected code
  always @(posedge clk_i) begin
    logic [DirBits-1:0] want;
    if (rst_ni && done_o) begin
      if (expected_dirs.size() == 0) begin
        note_error($sformatf("unexpected result, direction %0d", direction_o));
      end else begin
        want = expected_dirs.pop_front();
        if (direction_o !== want) begin
          note_error($sformatf("direction mismatch: expected %0d, got %0d",
                               want, direction_o));
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    test_reset();
    test_directed();
    wait_drained();
    test_random_points();
    test_boundary_points();
    test_extreme_points();
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (expected_dirs.size() != 0) begin
      note_error($sformatf("%0d results never arrived", expected_dirs.size()));
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/vdq_pkg.sv
sv/vdq_sector.sv
sv/vector_direction_quantizer_32.sv
bench/vector_direction_quantizer_32_tb.sv
